[src/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define CVB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define CVB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cvb_pkg.sv]
`timescale 1ns / 1ps
// types, constants and helper functions of the circle/box sweep block
// no dependencies
package cvb_pkg;

    localparam int MAX_BOXES     = 64;
    localparam int IDX_BITS      = $clog2(MAX_BOXES);
    localparam int CNT_BITS      = 7;
    localparam int COORD_BITS    = 24;
    localparam int FRACTION_BITS = 12;
    localparam int W2            = COORD_BITS + 4;
    localparam int PROD_BITS     = 2 * W2;
    localparam int ROT_BITS      = 16;
    localparam longint MOVE_EPS  = (64'd1 << FRACTION_BITS) / 64'd1000000;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [W2-1:0]         t_w2;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic [CNT_BITS-1:0]          t_cnt;
    typedef logic [IDX_BITS-1:0]          t_idx;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_HIT   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]          action;
        logic [5:0]          slot;
        t_coord              first_x;
        t_coord              first_y;
        t_coord              second_x;
        t_coord              second_y;
        logic                blocking;
        logic signed [ROT_BITS-1:0] rotation;
        t_coord              radius;
    } t_in_item;

    typedef struct packed {
        t_coord result_x;
        t_coord result_y;
        logic   hit;
    } t_out_item;

    typedef struct packed {
        t_coord cx;
        t_coord cy;
        t_coord w;
        t_coord h;
    } t_box;

    typedef struct packed {
        logic we;
        t_idx addr;
        t_box data;
    } t_box_wr;

    typedef struct packed {
        logic mv;
        logic in_ok;
        t_w2  ln;
        t_w2  un;
        t_w2  den;
    } t_slab;

    function automatic t_w2 dbl(input t_coord v);
        return t_w2'(v) <<< 1;
    endfunction

    function automatic logic still(input t_w2 v);
        t_w2 m;
        m = (v < 0) ? -v : v;
        return m <= t_w2'(MOVE_EPS);
    endfunction

    function automatic t_coord sat_coord(input t_w2 v);
        t_w2 hi;
        t_w2 lo;
        hi = t_w2'({1'b0, {(COORD_BITS-1){1'b1}}});
        lo = -hi - t_w2'(1);
        if (v > hi) begin
            return t_coord'(hi);
        end else if (v < lo) begin
            return t_coord'(lo);
        end
        return t_coord'(v);
    endfunction

    // one axis of the slab test, times as numerators over a non-negative denominator
    function automatic t_slab slab(input t_coord s, input t_coord e,
                                   input t_w2 lo2, input t_w2 hi2);
        t_slab r;
        t_w2   s2;
        t_w2   d;
        t_w2   n1;
        t_w2   n2;
        s2 = dbl(s);
        d  = t_w2'(e) - t_w2'(s);
        r.mv    = !still(d);
        r.in_ok = (s2 >= lo2) && (s2 <= hi2);
        n1 = lo2 - s2;
        n2 = hi2 - s2;
        r.den = d <<< 1;
        if (r.den < 0) begin
            n1    = -n1;
            n2    = -n2;
            r.den = -r.den;
        end
        r.ln = (n1 > n2) ? n2 : n1;
        r.un = (n1 > n2) ? n1 : n2;
        return r;
    endfunction

endpackage

[src/cvb_in_if.sv]
`timescale 1ns / 1ps
// valid/ready channels carrying input items and result items
// depends on cvb_pkg
interface cvb_in_if;
    logic              valid;
    logic              ready;
    cvb_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cvb_out_if;
    logic               valid;
    logic               ready;
    cvb_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/circle_vs_box_table_sweep_top.sv]
`timescale 1ns / 1ps
// top level of the circle/box sweep block: sequencer, box table, shared multiplier
// depends on cvb_pkg, cvb_in_if, cvb_box_ram, cvb_mul
//
// Keeps up to 64 axis-aligned boxes and answers move and hit queries against
// the first box_count entries (capped at 64). A write transaction gives no
// result. A move query runs two passes (x, then y at the resolved x); each
// pass with nonzero motion visits every scanned entry, with a table read,
// grown bounds and a clip compare on an active one and only the table read
// and active check on an inactive one. Each pass closes in an end-of-pass
// state, and a result state follows. A hit query takes an active entry
// through table read, grown bounds, slab setup and the single-axis checks
// (an inactive one only through the table read and active check), plus the
// cross-multiplied slab-time compares on the one shared multiplier where
// both axes move and the single-axis checks pass. Entries are visited one at
// a time over the single read port of the table and the shared multiplier.
// Input is taken only while the sequencer is idle; a finished result sits in
// an output register, so a new transaction can be accepted while it waits.
module circle_vs_box_table_sweep_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    cvb_in_if.sink                 i_in,
    cvb_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [cvb_pkg::CNT_BITS-1:0] i_cfg_wdata
);
    import cvb_pkg::*;

    // one-hot sequencer states
    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_RD   = 13'b0000000000010,
        S_PREP = 13'b0000000000100,
        S_EVAL = 13'b0000000001000,
        S_SLAB = 13'b0000000010000,
        S_CHK  = 13'b0000000100000,
        S_MA   = 13'b0000001000000,
        S_MB   = 13'b0000010000000,
        S_MC   = 13'b0000100000000,
        S_MD   = 13'b0001000000000,
        S_ME   = 13'b0010000000000,
        S_ENDP = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration and table valid bits
    t_cnt             r_count;
    logic [MAX_BOXES-1:0] r_active;

    // query context
    logic   r_op_hit;
    logic   r_yaxis;
    t_cnt   r_idx;
    t_cnt   r_n;
    t_coord r_fx, r_fy, r_sx, r_sy;
    t_w2    r_r2;

    // current sweep pass: start, other-axis coordinate, motion, target
    t_coord r_ps, r_po, r_pm;
    t_w2    r_t2;
    t_coord r_xr, r_yr;

    // grown bounds of the current box at doubled scale
    t_w2    r_lo2x, r_hi2x, r_lo2y, r_hi2y;
    t_slab  r_slx, r_sly;
    t_prod  r_pa;
    logic   r_hit;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // table and multiplier
    t_box_wr w_wr;
    t_box    w_rdata;
    t_w2     w_ma, w_mb;
    t_prod   w_prod;

    // sequencer helpers
    logic    w_accept;
    logic    w_last;
    logic    w_adv;
    t_cnt    w_n_in;
    t_coord  w_half;
    t_w2     w_half_w;
    logic    w_okx, w_oky;
    logic    w_out_free;
    // sweep compare
    t_w2     w_o2, w_s2, w_olo, w_ohi, w_lo, w_hi;
    logic    w_inside;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_last     = (r_idx + t_cnt'(1)) >= r_n;
    assign w_n_in     = (r_count > t_cnt'(MAX_BOXES)) ? t_cnt'(MAX_BOXES) : r_count;

    // table write on a write transaction
    always_comb begin
        w_wr.we   = w_accept && (i_in.data.action == ACT_WRITE)
                    && ({1'b0, i_in.data.slot} < t_cnt'(MAX_BOXES));
        w_wr.addr = t_idx'(i_in.data.slot);
        w_wr.data.cx = i_in.data.first_x;
        w_wr.data.cy = i_in.data.first_y;
        w_wr.data.w  = i_in.data.second_x;
        w_wr.data.h  = i_in.data.second_y;
    end

    cvb_box_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (r_idx[IDX_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    // multiplier operands: cross products of the two slab times
    always_comb begin
        w_ma = r_slx.ln;
        w_mb = r_sly.den;
        case (r_state)
            S_MB: begin
                w_ma = r_sly.un;
                w_mb = r_slx.den;
            end
            S_MC: begin
                w_ma = r_sly.ln;
                w_mb = r_slx.den;
            end
            S_MD: begin
                w_ma = r_slx.un;
                w_mb = r_sly.den;
            end
            default: begin
                w_ma = r_slx.ln;
                w_mb = r_sly.den;
            end
        endcase
    end

    cvb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // clip compare of one sweep pass
    always_comb begin
        w_o2     = dbl(r_po);
        w_s2     = dbl(r_ps);
        w_olo    = r_yaxis ? r_lo2x : r_lo2y;
        w_ohi    = r_yaxis ? r_hi2x : r_hi2y;
        w_lo     = r_yaxis ? r_lo2y : r_lo2x;
        w_hi     = r_yaxis ? r_hi2y : r_hi2x;
        w_inside = (w_o2 >= w_olo) && (w_o2 <= w_ohi);
    end

    // end of a pass: round toward the start, then saturate
    always_comb begin
        w_half_w = (r_pm > 0) ? (r_t2 >>> 1) : ((r_t2 + t_w2'(1)) >>> 1);
        w_half   = sat_coord(w_half_w);
    end

    // slab acceptance of each axis
    assign w_okx = r_slx.mv ? ((r_slx.un >= 0) && (r_slx.ln <= r_slx.den)) : r_slx.in_ok;
    assign w_oky = r_sly.mv ? ((r_sly.un >= 0) && (r_sly.ln <= r_sly.den)) : r_sly.in_ok;

    // next state and box advance
    always_comb begin
        n_state = r_state;
        w_adv   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.data.action)
                        ACT_MOVE: begin
                            n_state = (!still(t_w2'(i_in.data.second_x))
                                       && w_n_in != '0) ? S_RD : S_ENDP;
                        end
                        ACT_HIT: begin
                            n_state = (w_n_in != '0) ? S_RD : S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                if (!r_active[r_idx[IDX_BITS-1:0]]) begin
                    w_adv = 1'b1;
                end else begin
                    n_state = r_op_hit ? S_SLAB : S_EVAL;
                end
            end
            S_EVAL: begin
                w_adv = 1'b1;
            end
            S_SLAB: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!(w_okx && w_oky)) begin
                    w_adv = 1'b1;
                end else if (r_slx.mv && r_sly.mv) begin
                    n_state = S_MA;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MA: begin
                n_state = S_MB;
            end
            S_MB: begin
                n_state = S_MC;
            end
            S_MC: begin
                if (r_pa <= w_prod) begin
                    n_state = S_MD;
                end else begin
                    w_adv = 1'b1;
                end
            end
            S_MD: begin
                n_state = S_ME;
            end
            S_ME: begin
                if (r_pa <= w_prod) begin
                    n_state = S_DONE;
                end else begin
                    w_adv = 1'b1;
                end
            end
            S_ENDP: begin
                if (r_yaxis) begin
                    n_state = S_DONE;
                end else begin
                    n_state = (!still(t_w2'(r_sy)) && r_n != '0) ? S_RD : S_ENDP;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_adv) begin
            n_state = w_last ? (r_op_hit ? S_DONE : S_ENDP) : S_RD;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (w_wr.we) begin
                r_active[w_wr.addr] <= i_in.data.blocking
                                       && (i_in.data.rotation == '0);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_idx <= r_idx + t_cnt'(1);
        end
        case (r_state)
            S_IDLE: begin
                r_fx    <= i_in.data.first_x;
                r_fy    <= i_in.data.first_y;
                r_sx    <= i_in.data.second_x;
                r_sy    <= i_in.data.second_y;
                r_r2    <= (i_in.data.radius > 0) ? dbl(i_in.data.radius) : '0;
                r_n     <= w_n_in;
                r_idx   <= '0;
                r_op_hit <= (i_in.data.action == ACT_HIT);
                r_hit   <= 1'b0;
                r_yaxis <= 1'b0;
                r_ps    <= i_in.data.first_x;
                r_po    <= i_in.data.first_y;
                r_pm    <= i_in.data.second_x;
                r_t2    <= dbl(i_in.data.first_x) + dbl(i_in.data.second_x);
            end
            S_PREP: begin
                r_lo2x <= dbl(w_rdata.cx) - t_w2'(w_rdata.w) - r_r2;
                r_hi2x <= dbl(w_rdata.cx) + t_w2'(w_rdata.w) + r_r2;
                r_lo2y <= dbl(w_rdata.cy) - t_w2'(w_rdata.h) - r_r2;
                r_hi2y <= dbl(w_rdata.cy) + t_w2'(w_rdata.h) + r_r2;
            end
            S_EVAL: begin
                // clip at the near face when the motion crosses it
                if (w_inside) begin
                    if (r_pm > 0) begin
                        if (w_s2 <= w_lo && r_t2 > w_lo) begin
                            r_t2 <= w_lo;
                        end
                    end else begin
                        if (w_s2 >= w_hi && r_t2 < w_hi) begin
                            r_t2 <= w_hi;
                        end
                    end
                end
            end
            S_SLAB: begin
                r_slx <= slab(r_fx, r_sx, r_lo2x, r_hi2x);
                r_sly <= slab(r_fy, r_sy, r_lo2y, r_hi2y);
            end
            S_CHK: begin
                if (w_okx && w_oky && !(r_slx.mv && r_sly.mv)) begin
                    r_hit <= 1'b1;
                end
            end
            S_MB: begin
                r_pa <= w_prod;
            end
            S_MD: begin
                r_pa <= w_prod;
            end
            S_ME: begin
                if (r_pa <= w_prod) begin
                    r_hit <= 1'b1;
                end
            end
            S_ENDP: begin
                if (!r_yaxis) begin
                    // set up the vertical pass at the resolved x
                    r_xr    <= w_half;
                    r_yaxis <= 1'b1;
                    r_ps    <= r_fy;
                    r_po    <= w_half;
                    r_pm    <= r_sy;
                    r_t2    <= dbl(r_fy) + dbl(r_sy);
                    r_idx   <= '0;
                end else begin
                    r_yr <= w_half;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out.result_x <= r_op_hit ? t_coord'(0) : r_xr;
                    r_out.result_y <= r_op_hit ? t_coord'(0) : r_yr;
                    r_out.hit      <= r_op_hit && r_hit;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

[src/cvb_box_ram.sv]
`timescale 1ns / 1ps
// box table memory, one write port and one registered read port
// depends on cvb_pkg
module cvb_box_ram (
    input  logic             i_clk,
    input  cvb_pkg::t_box_wr i_wr,
    input  cvb_pkg::t_idx    i_raddr,
    output cvb_pkg::t_box    o_rdata
);
    import cvb_pkg::*;

    t_box r_mem [MAX_BOXES];
    t_box r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/cvb_mul.sv]
`timescale 1ns / 1ps
// shared signed multiplier with registered product
// depends on cvb_pkg
module cvb_mul (
    input  logic          i_clk,
    input  cvb_pkg::t_w2  i_a,
    input  cvb_pkg::t_w2  i_b,
    output cvb_pkg::t_prod o_prod
);
    import cvb_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_a) * t_prod'(i_b);
    end

    assign o_prod = r_prod;
endmodule

[src/cvb_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the circle/box sweep block, bound to the top level
// depends on cvb_pkg and assert_macros.svh
`include "assert_macros.svh"

module cvb_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic [1:0]             i_in_action,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input cvb_pkg::t_out_item     i_out_data
);
    import cvb_pkg::*;

    `CVB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `CVB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data), "result changed while stalled")
    `CVB_ASSERT_SAME(a_hit_zero, i_clk, i_rst_n, i_out_valid && i_out_data.hit, i_out_data.result_x == '0 && i_out_data.result_y == '0, "hit result with nonzero position")
    `CVB_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_action == ACT_WRITE && !i_out_valid, !i_out_valid, "write produced a result")
endmodule

bind circle_vs_box_table_sweep_top cvb_checker u_cvb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.data.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

[bench/tb_circle_vs_box_table_sweep_top.sv]
`timescale 1ns / 1ps
// self-checking bench for circle_vs_box_table_sweep_top: box writes, move and hit queries
// depends on cvb_pkg, cvb_in_if, cvb_out_if and the rtl of the block
module tb_circle_vs_box_table_sweep_top;
    import cvb_pkg::*;

    localparam longint ONE       = 64'sd1 << FRACTION_BITS;
    localparam int     IDLE_WAIT = 700;
    localparam int     WD_LIMIT  = 20000;
    localparam int     LONG_HOLD = 3000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [CNT_BITS-1:0] i_cfg_wdata;

    cvb_in_if  in_ch ();
    cvb_out_if out_ch ();

    circle_vs_box_table_sweep_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // box table as the predictor sees it
    longint    tab_cx [MAX_BOXES];
    longint    tab_cy [MAX_BOXES];
    longint    tab_w  [MAX_BOXES];
    longint    tab_h  [MAX_BOXES];
    bit        tab_on [MAX_BOXES];
    int        box_cnt;

    t_in_item  pend_q [$];    // items waiting for the driver
    t_out_item want_q [$];    // results still owed by the block
    bit        in_flight;
    bit        took;
    int        fails;
    int        wd_cnt;
    bit        hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint half_dn(input longint v);
        return (v >= 0) ? v / 2 : -((-v + 1) / 2);
    endfunction

    function automatic longint half_up(input longint v);
        return (v >= 0) ? (v + 1) / 2 : -((-v) / 2);
    endfunction

    function automatic longint sat_c(input longint v);
        longint hi;
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int scan_len();
        return (box_cnt > MAX_BOXES) ? MAX_BOXES : box_cnt;
    endfunction

    // bounds of a box grown by the radius, at twice the coordinate scale
    function automatic void grown_bounds(input int i, input bit yax, input longint r2,
                                         output longint lo2, output longint hi2);
        longint c2;
        longint s;
        c2  = 2 * (yax ? tab_cy[i] : tab_cx[i]);
        s   = yax ? tab_h[i] : tab_w[i];
        lo2 = c2 - s - r2;
        hi2 = c2 + s + r2;
    endfunction

    function automatic longint sweep_axis(input bit yax, input longint st, input longint oth,
                                          input longint mv, input longint r2);
        longint s2;
        longint o2;
        longint t2;
        longint lo2;
        longint hi2;
        longint olo2;
        longint ohi2;
        s2 = 2 * st;
        o2 = 2 * oth;
        t2 = s2 + 2 * mv;
        if (mag(mv) <= MOVE_EPS) return st + mv;
        for (int i = 0; i < scan_len(); i++) begin
            if (!tab_on[i]) continue;
            grown_bounds(i, !yax, r2, olo2, ohi2);
            if (o2 < olo2 || o2 > ohi2) continue;
            grown_bounds(i, yax, r2, lo2, hi2);
            if (mv > 0) begin
                if (s2 <= lo2 && t2 > lo2) t2 = lo2;
            end else begin
                if (s2 >= hi2 && t2 < hi2) t2 = hi2;
            end
        end
        return (mv > 0) ? half_dn(t2) : half_up(t2);
    endfunction

    // exact slab test of one grown box against the segment
    function automatic bit seg_meets(input int i, input longint st[2], input longint en[2],
                                     input longint r2);
        longint ln [3];
        longint un [3];
        longint dn [3];
        longint lo2;
        longint hi2;
        longint s2;
        longint d;
        longint n1;
        longint n2;
        longint den;
        longint tmp;
        int     k;
        k     = 1;
        ln[0] = 0;
        un[0] = 1;
        dn[0] = 1;
        for (int ax = 0; ax < 2; ax++) begin
            grown_bounds(i, ax == 1, r2, lo2, hi2);
            s2 = 2 * st[ax];
            d  = en[ax] - st[ax];
            if (mag(d) <= MOVE_EPS) begin
                if (s2 < lo2 || s2 > hi2) return 1'b0;
                continue;
            end
            n1  = lo2 - s2;
            n2  = hi2 - s2;
            den = 2 * d;
            if (den < 0) begin
                n1  = -n1;
                n2  = -n2;
                den = -den;
            end
            if (n1 > n2) begin
                tmp = n1;
                n1  = n2;
                n2  = tmp;
            end
            ln[k] = n1;
            un[k] = n2;
            dn[k] = den;
            k++;
        end
        // products stay well inside 64 bits at these widths
        for (int a = 0; a < k; a++)
            for (int b = 0; b < k; b++)
                if (ln[a] * dn[b] > un[b] * dn[a]) return 1'b0;
        return 1'b1;
    endfunction

    // applies one accepted item; returns 1 when it owes a result
    function automatic bit apply_item(input t_in_item it, output t_out_item res);
        longint fx;
        longint fy;
        longint sx;
        longint sy;
        longint rad;
        longint r2;
        longint xr;
        longint st [2];
        longint en [2];
        bit     h;
        fx  = longint'(t_coord'(it.first_x));
        fy  = longint'(t_coord'(it.first_y));
        sx  = longint'(t_coord'(it.second_x));
        sy  = longint'(t_coord'(it.second_y));
        rad = longint'(t_coord'(it.radius));
        r2  = (rad > 0) ? 2 * rad : 0;
        res = '0;
        case (t_action'(it.action))
            ACT_WRITE: begin
                tab_cx[it.slot] = fx;
                tab_cy[it.slot] = fy;
                tab_w[it.slot]  = sx;
                tab_h[it.slot]  = sy;
                tab_on[it.slot] = it.blocking && (it.rotation == 0);
                return 1'b0;
            end
            ACT_MOVE: begin
                xr = sat_c(sweep_axis(1'b0, fx, fy, sx, r2));
                res.result_x = t_coord'(xr);
                res.result_y = t_coord'(sat_c(sweep_axis(1'b1, fy, xr, sy, r2)));
                return 1'b1;
            end
            ACT_HIT: begin
                st[0] = fx;
                st[1] = fy;
                en[0] = sx;
                en[1] = sy;
                h     = 1'b0;
                for (int i = 0; i < scan_len() && !h; i++)
                    if (tab_on[i] && seg_meets(i, st, en, r2)) h = 1'b1;
                res.hit = h;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 9))
            0: return t_coord'($urandom);
            1: return $urandom_range(0, 1) ? t_coord'(24'h7fffff) : t_coord'(24'h800000);
            default: return t_coord'(longint'($urandom_range(0, 32 * ONE)) - 16 * ONE);
        endcase
    endfunction

    function automatic t_coord pick_size();
        case ($urandom_range(0, 9))
            0: return t_coord'($urandom);
            1: return t_coord'(-longint'($urandom_range(0, 2 * ONE)));
            default: return t_coord'($urandom_range(0, 8 * ONE));
        endcase
    endfunction

    function automatic t_coord pick_radius();
        case ($urandom_range(0, 9))
            0: return t_coord'($urandom);
            1: return t_coord'(-longint'($urandom_range(0, ONE)));
            2: return '0;
            default: return t_coord'($urandom_range(0, 2 * ONE));
        endcase
    endfunction

    function automatic t_in_item mk(input t_action a, input int sl, input longint fx,
                                    input longint fy, input longint sx, input longint sy,
                                    input bit blk, input int rot, input longint rad);
        t_in_item it;
        it.action   = a;
        it.slot     = sl[5:0];
        it.first_x  = t_coord'(fx);
        it.first_y  = t_coord'(fy);
        it.second_x = t_coord'(sx);
        it.second_y = t_coord'(sy);
        it.blocking = blk;
        it.rotation = rot[15:0];
        it.radius   = t_coord'(rad);
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        it.slot     = $urandom_range(0, 63);
        it.first_x  = pick_coord();
        it.first_y  = pick_coord();
        it.blocking = ($urandom_range(0, 7) != 0);
        it.rotation = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd0;
        it.radius   = pick_radius();
        r = $urandom_range(0, 99);
        if (r < 18) begin
            it.action   = ACT_WRITE;
            it.second_x = pick_size();
            it.second_y = pick_size();
        end else if (r < 58) begin
            it.action   = ACT_MOVE;
            it.second_x = ($urandom_range(0, 4) == 0) ? '0 : pick_coord();
            it.second_y = ($urandom_range(0, 4) == 0) ? '0 : pick_coord();
        end else if (r < 96) begin
            it.action   = ACT_HIT;
            it.second_x = ($urandom_range(0, 5) == 0) ? it.first_x : pick_coord();
            it.second_y = ($urandom_range(0, 5) == 0) ? it.first_y : pick_coord();
        end else begin
            it          = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
            it.action   = ACT_NONE;
        end
        return it;
    endfunction

    // ---------------------------------------------------------------- driver

    int burst_left;
    int gap_left;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (took) begin
                in_flight = 1'b0;
                took      = 1'b0;
            end
            if (!in_flight) begin
                if (burst_left == 0 && gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    in_ch.data  <= pend_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_flight = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        // no gap at all now and then, so runs of back-to-back transactions
                        gap_left = $urandom_range(0, 2) ? $urandom_range(0, 12) : 0;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver stalls

    int seg_left;
    int seg_mode;
    int hold_left;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_req) begin
            // long back-pressure so the block fills and stalls its input
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 80);
                seg_mode = $urandom_range(0, 2);
            end
            seg_left--;
            case (seg_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- monitor and checker

    always @(posedge i_clk) begin
        t_out_item res;
        t_out_item got;
        if (i_rst_n) begin
            wd_cnt++;
            // input side first so a result never overtakes its prediction
            if (in_ch.valid && in_ch.ready) begin
                took   = 1'b1;
                wd_cnt = 0;
                if (apply_item(in_ch.data, res)) want_q.push_back(res);
            end
            if (out_ch.valid && out_ch.ready) begin
                wd_cnt = 0;
                got    = out_ch.data;
                if (want_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fails++;
                end else begin
                    res = want_q.pop_front();
                    if (got.result_x !== res.result_x) begin
                        $error("result_x expected %0d got %0d", res.result_x, got.result_x);
                        fails++;
                    end
                    if (got.result_y !== res.result_y) begin
                        $error("result_y expected %0d got %0d", res.result_y, got.result_y);
                        fails++;
                    end
                    if (got.hit !== res.hit) begin
                        $error("hit expected %0d got %0d", res.hit, got.hit);
                        fails++;
                    end
                end
            end
            if (wd_cnt >= WD_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    // waits for the block to go idle, then lets any write still in work settle
    task automatic drain();
        while (pend_q.size() != 0 || in_flight || want_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_count(input int v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_BITS'(v);
        box_cnt = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    int counts [7] = '{64, 127, 1, 0, 9, 40, 64};

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_rst_n      = 1'b0;
        in_flight    = 1'b0;
        took         = 1'b0;
        hold_req     = 1'b0;
        fails        = 0;
        wd_cnt       = 0;
        burst_left   = 0;
        gap_left     = 0;
        seg_left     = 0;
        hold_left    = 0;
        box_cnt      = 0;
        foreach (tab_on[i]) tab_on[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every slot gets written once, inactive, so no scan ever reads an unwritten entry
        for (int s = 0; s < MAX_BOXES; s++)
            pend_q.push_back(mk(ACT_WRITE, s, 0, 0, ONE, ONE, 1'b0, 0, 0));
        // queries with box_count still at zero see an empty table
        pend_q.push_back(mk(ACT_MOVE, 0, 0, 0, 4 * ONE, -3 * ONE, 0, 0, ONE));
        pend_q.push_back(mk(ACT_HIT, 0, -ONE, 0, ONE, 0, 0, 0, ONE));
        drain();
        set_count(MAX_BOXES);

        // directed part
        pend_q.push_back(mk(ACT_WRITE, 0, 0, 0, 4 * ONE, 4 * ONE, 1, 0, 0));
        // rotated and non-blocking boxes stay inactive
        pend_q.push_back(mk(ACT_WRITE, 1, 0, 8 * ONE, ONE, ONE, 1, 5, 0));
        pend_q.push_back(mk(ACT_WRITE, 2, 0, -8 * ONE, ONE, ONE, 0, 0, 0));
        // negative width used as given, in the last slot
        pend_q.push_back(mk(ACT_WRITE, 63, 20 * ONE, 0, -2 * ONE, 2 * ONE, 1, 0, 0));
        pend_q.push_back(mk(ACT_WRITE, 5, -4096, 4095, 8191, 8191, 1, 16'h8000, 0));
        // positive move into box: clipped at the near face
        pend_q.push_back(mk(ACT_MOVE, 0, -10 * ONE, 0, 20 * ONE, 0, 0, 0, ONE));
        // negative move from the right
        pend_q.push_back(mk(ACT_MOVE, 0, 10 * ONE, ONE, -20 * ONE, 0, 0, 0, 0));
        // vertical pass, half-unit clip rounding with odd radius
        pend_q.push_back(mk(ACT_MOVE, 0, ONE, -10 * ONE, 0, 20 * ONE, 0, 0, 1));
        pend_q.push_back(mk(ACT_MOVE, 0, 0, 10 * ONE, 3, -20 * ONE, 0, 0, 3));
        // no motion at all, negative radius counts as zero
        pend_q.push_back(mk(ACT_MOVE, 0, 0, 0, 0, 0, 0, 0, -ONE));
        // saturation on both axes and both signs
        pend_q.push_back(mk(ACT_MOVE, 0, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
                            0, 0, 24'sh7fffff));
        pend_q.push_back(mk(ACT_MOVE, 0, -24'sh800000, -24'sh800000, -24'sh800000,
                            -24'sh800000, 0, 0, -24'sh800000));
        // hit: crossing, missing, point inside, point outside, diagonal corner
        pend_q.push_back(mk(ACT_HIT, 0, -10 * ONE, 0, 10 * ONE, 0, 0, 0, 0));
        pend_q.push_back(mk(ACT_HIT, 0, -10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE, 0, 0, 0));
        pend_q.push_back(mk(ACT_HIT, 0, ONE, ONE, ONE, ONE, 0, 0, 0));
        pend_q.push_back(mk(ACT_HIT, 0, 9 * ONE, 9 * ONE, 9 * ONE, 9 * ONE, 0, 0, ONE));
        pend_q.push_back(mk(ACT_HIT, 0, -6 * ONE, 0, 0, 6 * ONE, 0, 0, ONE));
        pend_q.push_back(mk(ACT_HIT, 0, -24'sh800000, -24'sh800000, 24'sh7fffff,
                            24'sh7fffff, 0, 0, 24'sh7fffff));
        // unused action: ignored, field extremes
        pend_q.push_back(mk(ACT_NONE, 63, 24'sh7fffff, -24'sh800000, -1, 24'sh7fffff,
                            1, 16'hffff, -1));
        pend_q.push_back(mk(ACT_HIT, 0, 0, -10 * ONE, 0, 10 * ONE, 0, 0, 0));
        drain();

        // random phases, each under its own box_count
        foreach (counts[p]) begin
            set_count(counts[p] == 40 ? $urandom_range(0, 127) : counts[p]);
            for (int n = 0; n < 215; n++) pend_q.push_back(rand_item());
            if (p == 1) begin
                // let the sender get going, then hold the receiver off
                repeat (50) @(posedge i_clk);
                hold_req = 1'b1;
            end
            drain();
        end

        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
